// ----- rtl/arpc_pkg.sv -----
// Shared types and constants of the ARP cache table.
// Used by arpc_mem, arpc_cmp and arp_cache_table; depends on nothing.
package arpc_pkg;

    localparam int ENTRIES_DEF     = 16;
    localparam int IP_W            = 32;
    localparam int MAC_W           = 48;
    localparam int STAMP_W         = 32;
    localparam int TIMEOUT_W       = 16;
    localparam int REMOVED_W       = 11;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd15;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_SWEEP  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2,
        STAT_RSVD = 2'd3
    } status_t;

    typedef struct packed {
        logic               valid;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic match;
        logic expired;
    } cmp_res_t;

endpackage

// ----- rtl/arpc_mem.sv -----
// Entry store: one write port, one registered read port.
// Depends on arpc_pkg for the entry type.
module arpc_mem #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [$clog2(ENTRIES)-1:0]  waddr,
    input  arpc_pkg::entry_t            wdata,
    input  logic [$clog2(ENTRIES)-1:0]  raddr,
    output arpc_pkg::entry_t            rdata
);
    import arpc_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/arpc_cmp.sv -----
// Shared compare unit: IP match and age-over-timeout test for one entry.
// Depends on arpc_pkg.
module arpc_cmp (
    input  arpc_pkg::entry_t                     entry,
    input  logic [arpc_pkg::IP_W-1:0]            ip,
    input  logic [arpc_pkg::STAMP_W-1:0]         now,
    input  logic [arpc_pkg::TIMEOUT_W-1:0]       timeout,
    output arpc_pkg::cmp_res_t                   res
);
    import arpc_pkg::*;

    logic [STAMP_W-1:0] age;

    always_comb begin
        age         = now - entry.stamp;
        res.match   = entry.valid && (entry.ip == ip);
        res.expired = entry.valid && (age > {{(STAMP_W-TIMEOUT_W){1'b0}}, timeout});
    end

endmodule

// ----- rtl/arp_cache_table.sv -----
// ARP cache table top level: sequencer scanning the entry store through one compare unit.
// Depends on arpc_pkg, arpc_mem and arpc_cmp.
//
//  channel   ports                                          direction
//  s_        s_valid/s_ready, req_type, ip_addr, mac_addr   in
//  m_        m_valid/m_ready, hit, found_mac, status,       out
//            removed_count
//  cfg_      cfg_valid/cfg_ready, cfg_wdata (timeout)       in
//
// Add, lookup and sweep scan every entry, one store read per cycle.
// Tick skips the scan.
// After reset a clearing pass writes every entry to zero before s_ready rises.
// A result waits in the output register; a new request is taken meanwhile and
// its result waits in S_OUT until the result ahead has been transferred.
module arp_cache_table #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic [arpc_pkg::IP_W-1:0]         s_ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]        s_mac_addr,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic [arpc_pkg::MAC_W-1:0]        m_found_mac,
    output logic [1:0]                        m_status,
    output logic [arpc_pkg::REMOVED_W-1:0]    m_removed_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [arpc_pkg::TIMEOUT_W-1:0]    cfg_wdata
);
    import arpc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_WRITE = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       addr_reg, addr_next;
    logic                   issue_reg, issue_next;
    logic                   rv_reg, rv_next;
    logic [IDX_W-1:0]       ridx_reg, ridx_next;
    req_t                   req_reg, req_next;
    logic [IP_W-1:0]        ip_reg, ip_next;
    logic [MAC_W-1:0]       mac_reg, mac_next;
    logic [STAMP_W-1:0]     now_reg, now_next;
    logic [TIMEOUT_W-1:0]   timeout_reg, timeout_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic                   free_reg, free_next;
    logic [IDX_W-1:0]       free_slot_reg, free_slot_next;
    logic [MAC_W-1:0]       fmac_reg, fmac_next;
    logic [REMOVED_W-1:0]   removed_reg, removed_next;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_hit_reg, m_hit_next;
    logic [MAC_W-1:0]       m_found_mac_reg, m_found_mac_next;
    status_t                m_status_reg, m_status_next;
    logic [REMOVED_W-1:0]   m_removed_reg, m_removed_next;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    entry_t                 mem_wdata;
    entry_t                 mem_rdata;
    cmp_res_t               cmp_res;
    logic                   out_free;

    arpc_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    arpc_cmp u_cmp (
        .entry   (mem_rdata),
        .ip      (ip_reg),
        .now     (now_reg),
        .timeout (timeout_reg),
        .res     (cmp_res)
    );

    assign s_ready         = (state_reg == S_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_found_mac     = m_found_mac_reg;
    assign m_status        = m_status_reg;
    assign m_removed_count = m_removed_reg;
    assign out_free        = !m_valid_reg || m_ready;

    always_comb begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        issue_next       = issue_reg;
        rv_next          = 1'b0;
        ridx_next        = addr_reg;
        req_next         = req_reg;
        ip_next          = ip_reg;
        mac_next         = mac_reg;
        now_next         = now_reg;
        timeout_next     = timeout_reg;
        found_next       = found_reg;
        slot_next        = slot_reg;
        free_next        = free_reg;
        free_slot_next   = free_slot_reg;
        fmac_next        = fmac_reg;
        removed_next     = removed_reg;
        m_valid_next     = m_valid_reg;
        m_hit_next       = m_hit_reg;
        m_found_mac_next = m_found_mac_reg;
        m_status_next    = m_status_reg;
        m_removed_next   = m_removed_reg;
        mem_we           = 1'b0;
        mem_waddr        = ridx_reg;
        mem_wdata        = mem_rdata;

        if (cfg_valid && cfg_ready) begin
            timeout_next = cfg_wdata;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST) begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_next     = req_t'(s_req_type);
                    ip_next      = s_ip_addr;
                    mac_next     = s_mac_addr;
                    found_next   = 1'b0;
                    free_next    = 1'b0;
                    removed_next = '0;
                    fmac_next    = '0;
                    addr_next    = '0;
                    if (req_t'(s_req_type) == REQ_TICK) begin
                        now_next   = now_reg + 1'b1;
                        state_next = S_OUT;
                    end else begin
                        issue_next = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (issue_reg) begin
                    addr_next = addr_reg + 1'b1;
                    rv_next   = 1'b1;
                    if (addr_reg == LAST) begin
                        issue_next = 1'b0;
                    end
                end
                if (rv_reg) begin
                    case (req_reg)
                        REQ_ADD, REQ_LOOKUP: begin
                            if (cmp_res.match && !found_reg) begin
                                found_next = 1'b1;
                                slot_next  = ridx_reg;
                                fmac_next  = mem_rdata.mac;
                            end
                            if (!mem_rdata.valid && !free_reg) begin
                                free_next      = 1'b1;
                                free_slot_next = ridx_reg;
                            end
                        end
                        REQ_SWEEP: begin
                            if (cmp_res.expired) begin
                                mem_we          = 1'b1;
                                mem_waddr       = ridx_reg;
                                mem_wdata.valid = 1'b0;
                                removed_next    = removed_reg + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (ridx_reg == LAST) begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                mem_wdata.valid = 1'b1;
                mem_wdata.ip    = ip_reg;
                mem_wdata.mac   = (req_reg == REQ_ADD) ? mac_reg : fmac_reg;
                mem_wdata.stamp = now_reg;
                mem_waddr       = found_reg ? slot_reg : free_slot_reg;
                case (req_reg)
                    REQ_ADD:    mem_we = found_reg || free_reg;
                    REQ_LOOKUP: mem_we = found_reg;
                    default:    mem_we = 1'b0;
                endcase
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_hit_next       = (req_reg == REQ_LOOKUP) && found_reg;
                    m_found_mac_next = ((req_reg == REQ_LOOKUP) && found_reg) ? fmac_reg : '0;
                    m_removed_next   = (req_reg == REQ_SWEEP) ? removed_reg : '0;
                    if ((req_reg == REQ_ADD) && !found_reg && !free_reg) begin
                        m_status_next = STAT_FULL;
                    end else if ((req_reg == REQ_LOOKUP) && !found_reg) begin
                        m_status_next = STAT_MISS;
                    end else begin
                        m_status_next = STAT_OK;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            addr_reg    <= '0;
            issue_reg   <= 1'b0;
            rv_reg      <= 1'b0;
            now_reg     <= '0;
            timeout_reg <= TIMEOUT_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            issue_reg   <= issue_next;
            rv_reg      <= rv_next;
            now_reg     <= now_next;
            timeout_reg <= timeout_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ridx_reg        <= ridx_next;
        req_reg         <= req_next;
        ip_reg          <= ip_next;
        mac_reg         <= mac_next;
        found_reg       <= found_next;
        slot_reg        <= slot_next;
        free_reg        <= free_next;
        free_slot_reg   <= free_slot_next;
        fmac_reg        <= fmac_next;
        removed_reg     <= removed_next;
        m_hit_reg       <= m_hit_next;
        m_found_mac_reg <= m_found_mac_next;
        m_status_reg    <= m_status_next;
        m_removed_reg   <= m_removed_next;
    end

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for arp_cache_table: directed table, then random request phases.
// Results are checked against a cache predictor held here. Depends on arpc_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arpc_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEF;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 216;
    localparam int IP_POOL     = 20;
    localparam int WATCHDOG    = 1000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 600;

    typedef struct packed {
        logic                 hit;
        logic [MAC_W-1:0]     mac;
        status_t              status;
        logic [REMOVED_W-1:0] removed;
    } arp_reply_t;

    typedef struct {
        bit               is_cfg;
        req_t             req;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        int               rep;
        bit               typed;
        arp_reply_t       reply;
    } dir_row_t;

    localparam arp_reply_t R_OK   = '{hit: 1'b0, mac: '0, status: STAT_OK, removed: '0};
    localparam arp_reply_t R_MISS = '{hit: 1'b0, mac: '0, status: STAT_MISS, removed: '0};
    localparam arp_reply_t R_FULL = '{hit: 1'b0, mac: '0, status: STAT_FULL, removed: '0};

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_req_type;
    logic [IP_W-1:0]       s_ip_addr;
    logic [MAC_W-1:0]      s_mac_addr;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_hit;
    logic [MAC_W-1:0]      m_found_mac;
    logic [1:0]            m_status;
    logic [REMOVED_W-1:0]  m_removed_count;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [TIMEOUT_W-1:0]  cfg_wdata;

    // predictor state
    logic                  mdl_valid [ENTRIES];
    logic [IP_W-1:0]       mdl_ip    [ENTRIES];
    logic [MAC_W-1:0]      mdl_mac   [ENTRIES];
    logic [STAMP_W-1:0]    mdl_stamp [ENTRIES];
    logic [STAMP_W-1:0]    mdl_now;
    logic [TIMEOUT_W-1:0]  mdl_timeout;

    arp_reply_t            replies_due [$];
    arp_reply_t            due;
    dir_row_t              dir_rows [$];
    logic [IP_W-1:0]       ip_pool [IP_POOL];
    logic [TIMEOUT_W-1:0]  phase_timeout [PHASES] = '{16'd0, 16'd1, 16'd3, 16'd7,
                                                      16'hFFFF, 16'd0, 16'd15};
    int                    reqs_sent;
    int                    quiet_cycles;
    bit                    failed;
    bit                    s_steady;
    bit                    m_steady;
    bit                    pressure_armed;

    arp_cache_table #(
        .ENTRIES(ENTRIES)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_ip_addr       (s_ip_addr),
        .s_mac_addr      (s_mac_addr),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_found_mac     (m_found_mac),
        .m_status        (m_status),
        .m_removed_count (m_removed_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_wdata       (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic int cache_find(input logic [IP_W-1:0] ip);
        int slot;
        slot = -1;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (mdl_valid[i] && mdl_ip[i] == ip) begin
                slot = i;
            end
        end
        return slot;
    endfunction

    function automatic arp_reply_t cache_predict(input req_t req, input logic [IP_W-1:0] ip,
                                                 input logic [MAC_W-1:0] mac);
        arp_reply_t         r;
        int                 slot;
        logic [STAMP_W-1:0] age;
        r = R_OK;
        case (req)
            REQ_ADD: begin
                slot = cache_find(ip);
                if (slot < 0) begin
                    for (int i = ENTRIES - 1; i >= 0; i--) begin
                        if (!mdl_valid[i]) begin
                            slot = i;
                        end
                    end
                end
                if (slot < 0) begin
                    r.status = STAT_FULL;
                end else begin
                    mdl_valid[slot] = 1'b1;
                    mdl_ip[slot]    = ip;
                    mdl_mac[slot]   = mac;
                    mdl_stamp[slot] = mdl_now;
                end
            end
            REQ_LOOKUP: begin
                slot = cache_find(ip);
                if (slot < 0) begin
                    r.status = STAT_MISS;
                end else begin
                    r.hit           = 1'b1;
                    r.mac           = mdl_mac[slot];
                    mdl_stamp[slot] = mdl_now;
                end
            end
            REQ_TICK: begin
                mdl_now = mdl_now + 1'b1;
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    age = mdl_now - mdl_stamp[i];
                    if (mdl_valid[i] && age > STAMP_W'(mdl_timeout)) begin
                        mdl_valid[i] = 1'b0;
                        r.removed    = r.removed + 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    function automatic void dir_add(input bit is_cfg, input req_t req, input logic [IP_W-1:0] ip,
                                    input logic [MAC_W-1:0] mac, input int rep, input bit typed,
                                    input arp_reply_t reply);
        dir_row_t row;
        row.is_cfg = is_cfg;
        row.req    = req;
        row.ip     = ip;
        row.mac    = mac;
        row.rep    = rep;
        row.typed  = typed;
        row.reply  = reply;
        dir_rows.push_back(row);
    endfunction

    task automatic send_req(input req_t req, input logic [IP_W-1:0] ip,
                            input logic [MAC_W-1:0] mac, input bit typed,
                            input arp_reply_t typed_reply);
        arp_reply_t r;
        int         g;
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_ip_addr  <= ip;
        s_mac_addr <= mac;
        do @(posedge aclk); while (!s_ready);
        r = cache_predict(req, ip, mac);
        replies_due.push_back(typed ? typed_reply : r);
        reqs_sent++;
        g = 0;
        if (!s_steady && $urandom_range(0, 2) == 0) begin
            g = gap_len();
        end
        if (g > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (g - 1) @(negedge aclk);
        end
    endtask

    // only with the block idle: every reply in and nothing on offer
    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        mdl_timeout = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result receiver, with one long hold-off to back the block up
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (pressure_armed && reqs_sent >= HOLD_AFTER) begin
                pressure_armed = 1'b0;
                stall_left     = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!m_steady && $urandom_range(0, 3) == 0) begin
                    stall_left = gap_len();
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $error("result transfer with no request outstanding");
                failed = 1'b1;
            end else begin
                due = replies_due.pop_front();
                if (m_hit !== due.hit) begin
                    $error("hit: expected %0d, got %0d", due.hit, m_hit);
                    failed = 1'b1;
                end
                if (m_found_mac !== due.mac) begin
                    $error("found_mac: expected %h, got %h", due.mac, m_found_mac);
                    failed = 1'b1;
                end
                if (m_status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, m_status);
                    failed = 1'b1;
                end
                if (m_removed_count !== due.removed) begin
                    $error("removed_count: expected %0d, got %0d", due.removed,
                           m_removed_count);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        dir_row_t         row;
        logic [63:0]      r64;
        logic [IP_W-1:0]  ip;
        req_t             rq;
        int               pick;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_req_type     = REQ_ADD;
        s_ip_addr      = '0;
        s_mac_addr     = '0;
        cfg_valid      = 1'b0;
        cfg_wdata      = '0;
        reqs_sent      = 0;
        quiet_cycles   = 0;
        failed         = 1'b0;
        s_steady       = 1'b0;
        m_steady       = 1'b0;
        pressure_armed = 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
            mdl_valid[i] = 1'b0;
            mdl_ip[i]    = '0;
            mdl_mac[i]   = '0;
            mdl_stamp[i] = '0;
        end
        mdl_now     = '0;
        mdl_timeout = TIMEOUT_RST;

        // directed: empty table, extremes, overwrite, full table, aging with zero and max timeout
        dir_add(0, REQ_LOOKUP, 32'h0, 48'h0, 1, 1, R_MISS);
        dir_add(0, REQ_SWEEP, 32'h0, 48'h0, 1, 1, R_OK);
        dir_add(0, REQ_ADD, 32'h0, 48'h0, 1, 1, R_OK);
        dir_add(0, REQ_ADD, '1, '1, 1, 1, R_OK);
        dir_add(0, REQ_LOOKUP, '1, 48'h0, 1, 1, '{1'b1, '1, STAT_OK, '0});
        dir_add(0, REQ_LOOKUP, 32'h0, 48'hA5A5_5A5A_A5A5, 1, 1, '{1'b1, '0, STAT_OK, '0});
        dir_add(0, REQ_ADD, '1, 48'h1234_5678_9ABC, 1, 1, R_OK);
        dir_add(0, REQ_LOOKUP, '1, 48'h0, 1, 1, '{1'b1, 48'h1234_5678_9ABC, STAT_OK, '0});
        dir_add(0, REQ_TICK, '1, '1, 1, 1, R_OK);
        dir_add(0, REQ_ADD, 32'h0A00_0000, 48'h0200_0000_0000, ENTRIES - 2, 1, R_OK);
        dir_add(0, REQ_ADD, 32'hC0A8_0001, 48'h0200_0000_00FF, 1, 1, R_FULL);
        dir_add(0, REQ_LOOKUP, 32'hC0A8_0001, 48'h0, 1, 1, R_MISS);
        dir_add(0, REQ_TICK, 32'h0, 48'h0, 3, 1, R_OK);
        dir_add(0, REQ_SWEEP, 32'h0, 48'h0, 1, 1, R_OK);
        dir_add(0, REQ_LOOKUP, 32'h0A00_0003, 48'h0, 1, 0, R_OK);
        dir_add(1, REQ_TICK, 32'h0, 48'h0, 1, 0, R_OK);
        dir_add(0, REQ_SWEEP, 32'h0, 48'h0, 1, 0, R_OK);
        dir_add(0, REQ_SWEEP, 32'h0, 48'h0, 1, 1, R_OK);
        dir_add(0, REQ_ADD, 32'h0A00_0000, 48'hFFFF_0000_FFFF, 1, 0, R_OK);
        dir_add(1, REQ_TICK, 32'h0000_FFFF, 48'h0, 1, 0, R_OK);
        dir_add(0, REQ_TICK, 32'h0, 48'h0, 1, 1, R_OK);
        dir_add(0, REQ_SWEEP, 32'h0, 48'h0, 1, 1, R_OK);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            if (row.is_cfg) begin
                write_timeout(row.ip[TIMEOUT_W-1:0]);
            end else begin
                for (int k = 0; k < row.rep; k++) begin
                    send_req(row.req, row.ip + k, row.mac + k, row.typed, row.reply);
                end
            end
        end

        // random phases over a small address pool so adds overwrite, lookups hit and the table fills
        for (int ph = 0; ph < PHASES; ph++) begin
            write_timeout(ph == 5 ? TIMEOUT_W'($urandom) : phase_timeout[ph]);
            s_steady = ($urandom_range(0, 3) == 0);
            m_steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < IP_POOL; k++) begin
                ip_pool[k] = $urandom;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                r64  = {$urandom, $urandom};
                ip   = $urandom;
                if (pick < 5) begin
                    rq = req_t'($urandom_range(0, 3));
                end else if (pick < 40) begin
                    rq = REQ_ADD;
                    ip = ip_pool[$urandom_range(0, IP_POOL - 1)];
                end else if (pick < 75) begin
                    rq = REQ_LOOKUP;
                    ip = ip_pool[$urandom_range(0, IP_POOL - 1)];
                end else if (pick < 92) begin
                    rq = REQ_TICK;
                end else begin
                    rq = REQ_SWEEP;
                end
                send_req(rq, ip, r64[MAC_W-1:0], 1'b0, R_OK);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);
        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- arp_cache_table.f -----
rtl/arpc_pkg.sv
rtl/arpc_mem.sv
rtl/arpc_cmp.sv
rtl/arp_cache_table.sv
dv/tb.sv
